// File: rtl/quaternion_vector_rotate_core_defines.svh
// Assertion macros shared by the quaternion rotation RTL.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define QVR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define QVR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define QVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/qvr_pkg.sv
// Types and fixed widths for the quaternion rotation core.
package qvr_pkg;

  // component width of every vector and quaternion part
  localparam int COMP_W = 32;
  // cross product q x v, exact
  localparam int C_W    = 65;
  // squared quaternion norm, unsigned
  localparam int N2_W   = 65;
  // partial products of a 32-bit part with a split cross term
  localparam int LO_W   = 66;
  localparam int HI_W   = 64;
  localparam int LO_SPLIT = 33;
  // full product of a 32-bit part with a cross term
  localparam int P_W    = 98;
  // numerator 2*(w*c + q x c)
  localparam int NUM_W  = 100;
  // quotient bits; the correction never exceeds twice the vector length
  localparam int QB     = 34;
  localparam int REM_W  = 65;

  // one queued word after the front end has classified it
  typedef struct packed {
    logic                        conj;   // rotate by the conjugate
    logic                        pass;   // zero quaternion, vector passes through
    logic [COMP_W-1:0]           w;
    logic [2:0][COMP_W-1:0]      q;
    logic [2:0][COMP_W-1:0]      v;
  } qvr_item_t;

  // queue status toward its neighbors
  typedef struct packed {
    logic full;
    logic valid;
  } qvr_fifo_stat_t;

endpackage

// File: rtl/quaternion_vector_rotate_core.sv
// Top level of the quaternion vector rotation core.
//
//  channel  | direction | ports                              | contents
//  ---------+-----------+------------------------------------+----------------------------------
//  in       | slave     | in_tvalid/tready/tdata/tuser       | vector, quaternion, command
//  out      | master    | out_tvalid/tready/tdata/tuser      | rotated vector, pass and sat flags
//
// Accepts one word per cycle and returns one word per cycle while out_tready stays high.
// The 34-stage long division forms the normalized correction term.
// Synchronous active-low reset empties the front register, queue and pipeline.
// A stalled output freezes the back end; the queue keeps absorbing input
// until it fills, then in_tready falls.
module quaternion_vector_rotate_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [223:0] in_tdata,   // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
  input  logic [0:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // out_x, out_y, out_z
  output logic [1:0]   out_tuser   // passed_through, saturated
);
  import qvr_pkg::*;

  logic           enq_valid;
  qvr_item_t      enq_item;
  qvr_item_t      deq_item;
  qvr_fifo_stat_t fifo_stat;
  logic           deq_pop;
  logic           enq_push;

  assign enq_push = enq_valid && !fifo_stat.full;

  qvr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .enq_valid (enq_valid),
    .enq_item  (enq_item),
    .fifo_stat (fifo_stat)
  );

  qvr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (enq_push),
    .push_item (enq_item),
    .pop       (deq_pop),
    .pop_item  (deq_item),
    .stat      (fifo_stat)
  );

  qvr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_stat  (fifo_stat),
    .deq_item   (deq_item),
    .pop        (deq_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/qvr_front.sv
// Front end: takes input words, decodes and classifies them, hands them to the queue.
module qvr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [223:0]          in_tdata,   // vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w
  input  logic [0:0]            in_tuser,   // command
  output logic                  enq_valid,
  output qvr_pkg::qvr_item_t    enq_item,
  input  qvr_pkg::qvr_fifo_stat_t fifo_stat
);
  import qvr_pkg::*;

  logic      front_valid_r;
  qvr_item_t front_item_r;
  qvr_item_t front_item_nxt;

  // holding register frees up whenever the queue has room
  assign in_tready = !front_valid_r || !fifo_stat.full;
  assign enq_valid = front_valid_r;
  assign enq_item  = front_item_r;

  // decode fields and flag the zero quaternion
  always_comb begin
    front_item_nxt.v[0] = in_tdata[31:0];
    front_item_nxt.v[1] = in_tdata[63:32];
    front_item_nxt.v[2] = in_tdata[95:64];
    front_item_nxt.q[0] = in_tdata[127:96];
    front_item_nxt.q[1] = in_tdata[159:128];
    front_item_nxt.q[2] = in_tdata[191:160];
    front_item_nxt.w    = in_tdata[223:192];
    front_item_nxt.conj = in_tuser[0];
    front_item_nxt.pass = (in_tdata[223:96] == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_tready) begin
      front_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      front_item_r <= front_item_nxt;
    end
  end

endmodule

// File: rtl/qvr_fifo.sv
// Short queue between the front end and the arithmetic pipeline.
`include "quaternion_vector_rotate_core_defines.svh"
module qvr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  qvr_pkg::qvr_item_t      push_item,
  input  logic                    pop,
  output qvr_pkg::qvr_item_t      pop_item,
  output qvr_pkg::qvr_fifo_stat_t stat
);
  import qvr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qvr_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign stat.valid = (cnt_r != '0);
  assign stat.full  = (cnt_r == CW'(DEPTH));
  assign pop_item   = mem_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `QVR_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(DEPTH), "queue count above depth")
  `QVR_ASSERT_IMPLY(a_no_overflow, push, !stat.full || pop, "push into full queue")
  `QVR_ASSERT_NEXT(a_pop_drains, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "pop lost")

endmodule

// File: rtl/qvr_back.sv
// Back end: cross products, exact numerator, pipelined long division, round and saturate.
`include "quaternion_vector_rotate_core_defines.svh"
module qvr_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  qvr_pkg::qvr_fifo_stat_t fifo_stat,
  input  qvr_pkg::qvr_item_t      deq_item,
  output logic                    pop,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [95:0]             out_tdata,  // out_x, out_y, out_z
  output logic [1:0]              out_tuser   // passed_through, saturated
);
  import qvr_pkg::*;

  logic adv;
  logic out_valid_r;

  // whole pipeline moves together unless the output word is stuck
  assign adv = !out_valid_r || out_tready;
  assign pop = adv && fifo_stat.valid;

  // ---------------- stage 1: products for q x v and the norm
  logic                     s1_valid_r;
  qvr_item_t                s1_item_r;
  logic signed [63:0]       s1_pc_r [6];
  logic signed [63:0]       s1_pc_nxt [6];
  logic [63:0]              s1_sq_r [4];
  logic signed [63:0]       s1_sq_nxt [4];

  always_comb begin
    s1_pc_nxt[0] = $signed(deq_item.q[1]) * $signed(deq_item.v[2]);
    s1_pc_nxt[1] = $signed(deq_item.q[2]) * $signed(deq_item.v[1]);
    s1_pc_nxt[2] = $signed(deq_item.q[2]) * $signed(deq_item.v[0]);
    s1_pc_nxt[3] = $signed(deq_item.q[0]) * $signed(deq_item.v[2]);
    s1_pc_nxt[4] = $signed(deq_item.q[0]) * $signed(deq_item.v[1]);
    s1_pc_nxt[5] = $signed(deq_item.q[1]) * $signed(deq_item.v[0]);
    s1_sq_nxt[0] = $signed(deq_item.q[0]) * $signed(deq_item.q[0]);
    s1_sq_nxt[1] = $signed(deq_item.q[1]) * $signed(deq_item.q[1]);
    s1_sq_nxt[2] = $signed(deq_item.q[2]) * $signed(deq_item.q[2]);
    s1_sq_nxt[3] = $signed(deq_item.w) * $signed(deq_item.w);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r <= deq_item;
      for (int i = 0; i < 6; i++) s1_pc_r[i] <= s1_pc_nxt[i];
      for (int i = 0; i < 4; i++) s1_sq_r[i] <= s1_sq_nxt[i];
    end
  end

  // ---------------- stage 2: c = q x v, n2 = |q|^2
  logic                     s2_valid_r;
  qvr_item_t                s2_item_r;
  logic signed [C_W-1:0]    s2_c_r [3];
  logic [N2_W-1:0]          s2_n2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item_r <= s1_item_r;
      for (int i = 0; i < 3; i++) begin
        s2_c_r[i] <= C_W'(s1_pc_r[2*i]) - C_W'(s1_pc_r[2*i+1]);
      end
      s2_n2_r <= N2_W'(s1_sq_r[0]) + N2_W'(s1_sq_r[1])
               + N2_W'(s1_sq_r[2]) + N2_W'(s1_sq_r[3]);
    end
  end

  // ---------------- stage 3: split partial products of w*c and q x c
  // order: w*c0, w*c1, w*c2, q1*c2, q2*c1, q2*c0, q0*c2, q0*c1, q1*c0
  logic                     s3_valid_r;
  logic                     s3_conj_r, s3_pass_r;
  logic [2:0][COMP_W-1:0]   s3_v_r;
  logic [N2_W-1:0]          s3_n2_r;
  logic signed [LO_W-1:0]   s3_lo_r [9];
  logic signed [HI_W-1:0]   s3_hi_r [9];
  logic signed [LO_W-1:0]   s3_lo_nxt [9];
  logic signed [HI_W-1:0]   s3_hi_nxt [9];
  logic [COMP_W-1:0]        mul_a [9];
  logic [C_W-1:0]           mul_c [9];

  always_comb begin
    mul_a[0] = s2_item_r.w;    mul_c[0] = s2_c_r[0];
    mul_a[1] = s2_item_r.w;    mul_c[1] = s2_c_r[1];
    mul_a[2] = s2_item_r.w;    mul_c[2] = s2_c_r[2];
    mul_a[3] = s2_item_r.q[1]; mul_c[3] = s2_c_r[2];
    mul_a[4] = s2_item_r.q[2]; mul_c[4] = s2_c_r[1];
    mul_a[5] = s2_item_r.q[2]; mul_c[5] = s2_c_r[0];
    mul_a[6] = s2_item_r.q[0]; mul_c[6] = s2_c_r[2];
    mul_a[7] = s2_item_r.q[0]; mul_c[7] = s2_c_r[1];
    mul_a[8] = s2_item_r.q[1]; mul_c[8] = s2_c_r[0];
    for (int k = 0; k < 9; k++) begin
      s3_lo_nxt[k] = $signed(mul_a[k]) * $signed({1'b0, mul_c[k][LO_SPLIT-1:0]});
      s3_hi_nxt[k] = $signed(mul_a[k]) * $signed(mul_c[k][C_W-1:LO_SPLIT]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_conj_r <= s2_item_r.conj;
      s3_pass_r <= s2_item_r.pass;
      s3_v_r    <= s2_item_r.v;
      s3_n2_r   <= s2_n2_r;
      for (int k = 0; k < 9; k++) begin
        s3_lo_r[k] <= s3_lo_nxt[k];
        s3_hi_r[k] <= s3_hi_nxt[k];
      end
    end
  end

  // ---------------- stage 4: recombine the halves
  logic                     s4_valid_r;
  logic                     s4_conj_r, s4_pass_r;
  logic [2:0][COMP_W-1:0]   s4_v_r;
  logic [N2_W-1:0]          s4_n2_r;
  logic signed [P_W-1:0]    s4_prod_r [9];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_conj_r <= s3_conj_r;
      s4_pass_r <= s3_pass_r;
      s4_v_r    <= s3_v_r;
      s4_n2_r   <= s3_n2_r;
      for (int k = 0; k < 9; k++) begin
        s4_prod_r[k] <= (P_W'(s3_hi_r[k]) <<< LO_SPLIT) + P_W'(s3_lo_r[k]);
      end
    end
  end

  // ---------------- stage 5: num = 2*(w*c + q x c); conjugate flips w*c only
  logic                     s5_valid_r;
  logic                     s5_pass_r;
  logic [2:0][COMP_W-1:0]   s5_v_r;
  logic [N2_W-1:0]          s5_n2_r;
  logic signed [NUM_W-1:0]  s5_num_r [3];
  logic signed [NUM_W-1:0]  s5_num_nxt [3];
  logic signed [P_W-1:0]    wc_term [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wc_term[i]    = s4_conj_r ? -s4_prod_r[i] : s4_prod_r[i];
      s5_num_nxt[i] = (NUM_W'(wc_term[i]) + NUM_W'(s4_prod_r[3+2*i])
                      - NUM_W'(s4_prod_r[4+2*i])) <<< 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_pass_r <= s4_pass_r;
      s5_v_r    <= s4_v_r;
      s5_n2_r   <= s4_n2_r;
      for (int i = 0; i < 3; i++) s5_num_r[i] <= s5_num_nxt[i];
    end
  end

  // ---------------- division: entry stage 0 takes the magnitude, then one bit per stage
  logic                     dv_valid_r [QB+1];
  logic                     dv_pass_r  [QB+1];
  logic [2:0][COMP_W-1:0]   dv_v_r     [QB+1];
  logic [N2_W-1:0]          dv_n2_r    [QB+1];
  logic [2:0]               dv_neg_r   [QB+1];
  logic [REM_W-1:0]         dv_rem_r   [QB+1][3];
  logic [QB-1:0]            dv_qn_r    [QB+1][3];
  logic [REM_W-1:0]         dv_rem_nxt [QB+1][3];
  logic [QB-1:0]            dv_qn_nxt  [QB+1][3];
  logic [2:0]               dv_neg0_nxt;
  logic [NUM_W-1:0]         dv_mag [3];
  logic [REM_W:0]           dv_trial [QB+1][3];
  logic                     dv_ge    [QB+1][3];

  always_comb begin
    // magnitude split into starting remainder and dividend bits
    for (int i = 0; i < 3; i++) begin
      dv_neg0_nxt[i]   = s5_num_r[i][NUM_W-1];
      dv_mag[i]        = dv_neg0_nxt[i] ? NUM_W'(-s5_num_r[i]) : NUM_W'(s5_num_r[i]);
      dv_rem_nxt[0][i] = dv_mag[i][QB+REM_W-1:QB];
      dv_qn_nxt[0][i]  = dv_mag[i][QB-1:0];
      dv_trial[0][i]   = '0;
      dv_ge[0][i]      = 1'b0;
    end
    // restoring step per stage, quotient bits shift in from the bottom
    for (int j = 1; j <= QB; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_trial[j][i] = {dv_rem_r[j-1][i], dv_qn_r[j-1][i][QB-1]};
        dv_ge[j][i]    = (dv_trial[j][i] >= {1'b0, dv_n2_r[j-1]});
        dv_rem_nxt[j][i] = dv_ge[j][i]
                         ? REM_W'(dv_trial[j][i] - {1'b0, dv_n2_r[j-1]})
                         : dv_trial[j][i][REM_W-1:0];
        dv_qn_nxt[j][i]  = {dv_qn_r[j-1][i][QB-2:0], dv_ge[j][i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_pass_r[0] <= s5_pass_r;
      dv_v_r[0]    <= s5_v_r;
      dv_n2_r[0]   <= s5_n2_r;
      dv_neg_r[0]  <= dv_neg0_nxt;
      for (int j = 1; j <= QB; j++) begin
        dv_pass_r[j] <= dv_pass_r[j-1];
        dv_v_r[j]    <= dv_v_r[j-1];
        dv_n2_r[j]   <= dv_n2_r[j-1];
        dv_neg_r[j]  <= dv_neg_r[j-1];
      end
      for (int j = 0; j <= QB; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[j][i] <= dv_rem_nxt[j][i];
          dv_qn_r[j][i]  <= dv_qn_nxt[j][i];
        end
      end
    end
  end

  // ---------------- stage F1: round half up on magnitude, restore sign
  logic                     f1_valid_r;
  logic                     f1_pass_r;
  logic [2:0][COMP_W-1:0]   f1_v_r;
  logic signed [QB+1:0]     f1_corr_r [3];
  logic signed [QB+1:0]     f1_corr_nxt [3];
  logic [QB:0]              f1_qr [3];
  logic                     f1_up [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1_up[i]       = ({dv_rem_r[QB][i], 1'b0} >= {1'b0, dv_n2_r[QB]});
      f1_qr[i]       = {1'b0, dv_qn_r[QB][i]} + (QB+1)'(f1_up[i]);
      f1_corr_nxt[i] = dv_neg_r[QB][i] ? -$signed({1'b0, f1_qr[i]})
                                       : $signed({1'b0, f1_qr[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_pass_r <= dv_pass_r[QB];
      f1_v_r    <= dv_v_r[QB];
      for (int i = 0; i < 3; i++) f1_corr_r[i] <= f1_corr_nxt[i];
    end
  end

  // ---------------- output register: add to vector and clamp
  logic [2:0][COMP_W-1:0]   out_xyz_r, out_xyz_nxt;
  logic                     out_pass_r, out_sat_r, out_sat_nxt;
  logic signed [QB+2:0]     o_sum [3];
  logic                     o_hi [3], o_lo [3];

  always_comb begin
    out_sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o_sum[i] = (QB+3)'($signed(f1_v_r[i])) + (QB+3)'(f1_corr_r[i]);
      o_hi[i]  = (o_sum[i] > (QB+3)'($signed({1'b0, {(COMP_W-1){1'b1}}})));
      o_lo[i]  = (o_sum[i] < (QB+3)'($signed({1'b1, {(COMP_W-1){1'b0}}})));
      if (f1_pass_r) begin
        out_xyz_nxt[i] = f1_v_r[i];
      end else if (o_hi[i]) begin
        out_xyz_nxt[i] = {1'b0, {(COMP_W-1){1'b1}}};
      end else if (o_lo[i]) begin
        out_xyz_nxt[i] = {1'b1, {(COMP_W-1){1'b0}}};
      end else begin
        out_xyz_nxt[i] = o_sum[i][COMP_W-1:0];
      end
      if (!f1_pass_r && (o_hi[i] || o_lo[i])) out_sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_xyz_r  <= out_xyz_nxt;
      out_pass_r <= f1_pass_r;
      out_sat_r  <= out_sat_nxt;
    end
  end

  // valid pipe for every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      for (int j = 0; j <= QB; j++) dv_valid_r[j] <= 1'b0;
      f1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r    <= fifo_stat.valid;
      s2_valid_r    <= s1_valid_r;
      s3_valid_r    <= s2_valid_r;
      s4_valid_r    <= s3_valid_r;
      s5_valid_r    <= s4_valid_r;
      dv_valid_r[0] <= s5_valid_r;
      for (int j = 1; j <= QB; j++) dv_valid_r[j] <= dv_valid_r[j-1];
      f1_valid_r    <= dv_valid_r[QB];
      out_valid_r   <= f1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_xyz_r;
  assign out_tuser  = {out_sat_r, out_pass_r};

  `QVR_ASSERT_IMPLY(a_pass_no_sat, out_valid_r && out_pass_r, !out_sat_r,
    "pass-through word flagged saturated")
  `QVR_ASSERT_IMPLY(a_rem_bound, dv_valid_r[QB] && !dv_pass_r[QB],
    dv_rem_r[QB][0] < dv_n2_r[QB], "division remainder not below divisor")
  `QVR_ASSERT_NEXT(a_f1_to_out, f1_valid_r && adv, out_valid_r,
    "finished word dropped before output")

endmodule
